>>> rtl/ifp_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 fragment planner package
// Shared widths, register indexes, the descriptor type and the fragment size
// clamp used by the planner and its cutting sequencer.
// ----------------------------------------------------------------------------
package ifp_pkg;

  localparam int unsigned HEADER_BYTES = 20;
  localparam int unsigned MIN_FRAG     = 1024;
  localparam int unsigned MAX_FRAG     = 8192;
  localparam int unsigned MAX_FULL     = 63;

  localparam int unsigned SIZE_W  = 16;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned FRAG_W  = 14;
  localparam int unsigned OFFU_W  = 13;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned CFG_W   = 16;

  localparam logic REG_FRAG_PAYLOAD = 1'b0;
  localparam logic REG_ID_BASE      = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]   identification;
    logic [SIZE_W-1:0] payload_start;
    logic [FRAG_W-1:0] payload_bytes;
    logic              more_fragments;
    logic              fragmented;
    logic              last;
  } ifp_desc_t;

  function automatic logic [FRAG_W-1:0] clamp_frag(input logic [FRAG_W-1:0] v);
    logic [FRAG_W-1:0] f8;
    f8 = {v[FRAG_W-1:3], 3'b000};
    if (f8 < FRAG_W'(MIN_FRAG)) begin
      f8 = FRAG_W'(MIN_FRAG);
    end else if (f8 > FRAG_W'(MAX_FRAG)) begin
      f8 = FRAG_W'(MAX_FRAG);
    end
    return f8;
  endfunction

endpackage

>>> rtl/ifp_cutter.sv
// ----------------------------------------------------------------------------
// IPv4 fragment cutting sequencer
// Walks one datagram with a single shared subtract and compare unit, giving
// one fragment descriptor per step and keeping the identification counter.
// ----------------------------------------------------------------------------
module ifp_cutter
  import ifp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SIZE_W-1:0] size,
  input  logic [ID_W-1:0]   hid,
  input  logic [FRAG_W-1:0] frag_cfg,
  input  logic [ID_W-1:0]   id_base,
  input  logic              advance,
  output logic              busy,
  output logic              desc_valid,
  output ifp_desc_t         desc
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic               state_r, state_nxt;
  logic [SIZE_W-1:0]  rem_r, rem_nxt;
  logic [SIZE_W-1:0]  off_r, off_nxt;
  logic [ID_W-1:0]    hid_r, hid_nxt;
  logic [ID_W-1:0]    id_r, id_nxt;
  logic [FRAG_W-1:0]  f_r, f_nxt;
  logic [COUNT_W-1:0] k_r, k_nxt;
  logic               first_r, first_nxt;
  logic [ID_W-1:0]    id_counter_r, id_counter_nxt;

  logic [SIZE_W:0]    diff;
  logic               gt;
  logic               full;
  logic               pass;
  logic               step;

  assign diff = {1'b0, rem_r} - {{(SIZE_W+1-FRAG_W){1'b0}}, f_r};
  assign gt   = !diff[SIZE_W] && (diff[SIZE_W-1:0] != '0);
  assign full = gt && (k_r != COUNT_W'(MAX_FULL));
  assign pass = first_r && !gt;
  assign step = (state_r == ST_RUN) && advance;

  assign busy       = (state_r == ST_RUN);
  assign desc_valid = (state_r == ST_RUN);

  always_comb begin
    desc.identification = pass ? hid_r : id_r;
    desc.payload_start  = off_r;
    desc.payload_bytes  = full ? f_r : rem_r[FRAG_W-1:0];
    desc.more_fragments = full;
    desc.fragmented     = !pass;
    desc.last           = !full;
  end

  always_comb begin
    state_nxt      = state_r;
    rem_nxt        = rem_r;
    off_nxt        = off_r;
    hid_nxt        = hid_r;
    id_nxt         = id_r;
    f_nxt          = f_r;
    k_nxt          = k_r;
    first_nxt      = first_r;
    id_counter_nxt = id_counter_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
          rem_nxt   = size;
          off_nxt   = '0;
          hid_nxt   = hid;
          id_nxt    = id_base + id_counter_r;
          f_nxt     = clamp_frag(frag_cfg);
          k_nxt     = '0;
          first_nxt = 1'b1;
        end
      end
      ST_RUN: begin
        if (step) begin
          if (full) begin
            rem_nxt   = diff[SIZE_W-1:0];
            off_nxt   = off_r + {{(SIZE_W-FRAG_W){1'b0}}, f_r};
            k_nxt     = k_r + 1'b1;
            first_nxt = 1'b0;
          end else begin
            state_nxt = ST_IDLE;
            rem_nxt   = '0;
            off_nxt   = '0;
            if (!pass) begin
              id_counter_nxt = id_counter_r + {{(ID_W-COUNT_W){1'b0}}, k_r} + 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      id_counter_r <= '0;
      rem_r        <= '0;
      off_r        <= '0;
      k_r          <= '0;
      first_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      id_counter_r <= id_counter_nxt;
      rem_r        <= rem_nxt;
      off_r        <= off_nxt;
      k_r          <= k_nxt;
      first_r      <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hid_r <= hid_nxt;
    id_r  <= id_nxt;
    f_r   <= f_nxt;
  end

endmodule

>>> rtl/ipv4_fragment_planner.sv
// ----------------------------------------------------------------------------
// IPv4 fragment planner
// Takes the payload size of one datagram and returns one descriptor per
// fragment, with identification, offset, flags and lengths.
//
//   Channel  Direction  Handshake           Payload
//   in       input      in_valid/in_stall   payload_size, header_id
//   out      output     out_valid/out_stall fragment descriptor fields
//   cfg      input      cfg_we              cfg_index, cfg_wdata
//
// An item is loaded and then cut into its descriptors; the shared subtract
// and compare unit decides one fragment a cycle unless a stalled output holds it.
// A finished descriptor waits in the output register while the next is cut.
// The input is stalled from acceptance until the last descriptor is loaded.
// Reset restores the register defaults and clears the identification counter.
// ----------------------------------------------------------------------------
module ipv4_fragment_planner
  import ifp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [SIZE_W-1:0] in_payload_size,
  input  logic [ID_W-1:0]   in_header_id,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ID_W-1:0]   out_identification,
  output logic [OFFU_W-1:0] out_offset_units,
  output logic              out_more_fragments,
  output logic [SIZE_W-1:0] out_frag_length,
  output logic [SIZE_W-1:0] out_payload_start,
  output logic [FRAG_W-1:0] out_payload_bytes,
  output logic              out_fragmented,
  output logic              out_last
);

  logic [FRAG_W-1:0] frag_cfg_r;
  logic [ID_W-1:0]   id_base_r;
  logic              out_valid_r, out_valid_nxt;
  ifp_desc_t         out_desc_r;
  logic              busy;
  logic              desc_valid;
  ifp_desc_t         desc;
  logic              load;
  logic              start;

  assign load  = !out_valid_r || !out_stall;
  assign start = in_valid && !busy;

  ifp_cutter u_cutter (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .size       (in_payload_size),
    .hid        (in_header_id),
    .frag_cfg   (frag_cfg_r),
    .id_base    (id_base_r),
    .advance    (load),
    .busy       (busy),
    .desc_valid (desc_valid),
    .desc       (desc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frag_cfg_r <= FRAG_W'(1480);
      id_base_r  <= ID_W'(16'h1230);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAG_PAYLOAD: frag_cfg_r <= cfg_wdata[FRAG_W-1:0];
        REG_ID_BASE:      id_base_r  <= cfg_wdata[ID_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = desc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && desc_valid) begin
      out_desc_r <= desc;
    end
  end

  assign in_stall           = busy;
  assign out_valid          = out_valid_r;
  assign out_identification = out_desc_r.identification;
  assign out_offset_units   = out_desc_r.payload_start[SIZE_W-1:3];
  assign out_more_fragments = out_desc_r.more_fragments;
  assign out_frag_length    = {{(SIZE_W-FRAG_W){1'b0}}, out_desc_r.payload_bytes}
                              + SIZE_W'(HEADER_BYTES);
  assign out_payload_start  = out_desc_r.payload_start;
  assign out_payload_bytes  = out_desc_r.payload_bytes;
  assign out_fragmented     = out_desc_r.fragmented;
  assign out_last           = out_desc_r.last;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a transfer");

  a_mid_is_split: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_fragmented && out_more_fragments)
    else $error("non-final descriptor without fragment flags");

  a_passthrough_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fragmented |-> out_last && (out_payload_start == '0))
    else $error("passthrough descriptor malformed");
`endif

endmodule
